[rtl/rrs_pkg.sv]
// Shared types and constants for the round-robin slice scheduler.
// No dependencies; every other rtl file imports this package.
package rrs_pkg;

	// table geometry
	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	// field widths
	localparam int TIME_W = 16;
	localparam int CLK_W  = 20;
	localparam int SUM_W  = 24;
	localparam int PNUM_W = 5;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;

	// saturation limits
	localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

	localparam logic [TIME_W-1:0] QUANTUM_RST = TIME_W'(4);

	// request codes; the unused code falls to default arms
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_STEP  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_RUN,
		S_FINISH,
		S_ACCUM,
		S_EMIT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;
		logic load;
		logic clear;
		logic none;
		logic scan_adv;
		logic run;
		logic finish;
		logic accum;
		logic emit;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		req_t req;
		logic no_work;
		logic hit;
	} sts_t;

endpackage

[rtl/rrs_ctrl.sv]
// Controller state machine of the round-robin slice scheduler.
// Depends on rrs_pkg; drives rrs_dp through cmd_t and reads sts_t.
module rrs_ctrl
	import rrs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	output logic   out_valid,
	input  logic   out_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat valid: set on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.req)
					REQ_LOAD: begin
						cmd.load = 1'b1;
						state_d  = S_EMIT;
					end
					REQ_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_EMIT;
					end
					REQ_STEP: begin
						if (sts.no_work) begin
							cmd.none = 1'b1;
							state_d  = S_EMIT;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						state_d = S_EMIT;
					end
				endcase
			end
			S_SCAN: begin
				// walk one entry per cycle until one has work left
				if (sts.hit) begin
					state_d = S_RUN;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			S_RUN: begin
				cmd.run = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_ACCUM;
			end
			S_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/rrs_dp.sv]
// Datapath of the round-robin slice scheduler: burst tables, clock,
// totals, result registers and output register. Depends on rrs_pkg.
module rrs_dp
	import rrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [TIME_W-1:0] burst_time,
	output logic [STAT_W-1:0] status,
	output logic [PNUM_W-1:0] proc_number,
	output logic [TIME_W-1:0] slice_length,
	output logic [CLK_W-1:0]  slice_end,
	output logic              finished,
	output logic [CLK_W-1:0]  turnaround,
	output logic [CLK_W-1:0]  waiting,
	output logic              all_done,
	output logic [SUM_W-1:0]  total_turnaround,
	output logic [SUM_W-1:0]  total_waiting
);

	// burst tables, no reset: entries at or above the count are never read
	logic [TIME_W-1:0] rem_q  [MAX_PROCS];
	logic [TIME_W-1:0] orig_q [MAX_PROCS];

	// architectural state
	logic [TIME_W-1:0] quantum_q;
	logic [CNT_W-1:0]  proc_cnt_q;
	logic [CNT_W-1:0]  active_q;
	logic [IDX_W-1:0]  cursor_q;
	logic [CLK_W-1:0]  clock_q;
	logic [SUM_W-1:0]  sum_tat_q;
	logic [SUM_W-1:0]  sum_wt_q;

	// per-request working registers
	req_t              req_q;
	logic [TIME_W-1:0] burst_q;
	logic [IDX_W-1:0]  scan_idx_q;
	stat_t             res_stat_q;
	logic [PNUM_W-1:0] res_pnum_q;
	logic [TIME_W-1:0] res_slen_q;
	logic              res_fin_q;
	logic [CLK_W-1:0]  res_tat_q;
	logic [CLK_W-1:0]  res_wt_q;

	// output register
	logic [STAT_W-1:0] o_stat_q;
	logic [PNUM_W-1:0] o_pnum_q;
	logic [TIME_W-1:0] o_slen_q;
	logic [CLK_W-1:0]  o_end_q;
	logic              o_fin_q;
	logic [CLK_W-1:0]  o_tat_q;
	logic [CLK_W-1:0]  o_wt_q;
	logic              o_done_q;
	logic [SUM_W-1:0]  o_sum_tat_q;
	logic [SUM_W-1:0]  o_sum_wt_q;

	logic              full;
	logic [IDX_W-1:0]  load_idx;
	logic [TIME_W-1:0] rem_rd;
	logic [TIME_W-1:0] orig_rd;
	logic [TIME_W-1:0] q_eff;
	logic [TIME_W-1:0] slen;
	logic [CNT_W-1:0]  idx_inc;
	logic [IDX_W-1:0]  idx_next;
	logic [CLK_W:0]    clk_sum;
	logic [CLK_W-1:0]  orig_ext;
	logic [CLK_W-1:0]  wt;
	logic [SUM_W:0]    tat_sum;
	logic [SUM_W:0]    wt_sum;

	// table access and slice arithmetic
	always_comb begin
		full     = (proc_cnt_q == CNT_W'(MAX_PROCS));
		load_idx = proc_cnt_q[IDX_W-1:0];
		rem_rd   = rem_q[scan_idx_q];
		orig_rd  = orig_q[scan_idx_q];
		q_eff    = (quantum_q == '0) ? TIME_W'(1) : quantum_q;
		slen     = (rem_rd < q_eff) ? rem_rd : q_eff;
		idx_inc  = CNT_W'(scan_idx_q) + CNT_W'(1);
		idx_next = (idx_inc == proc_cnt_q) ? '0 : idx_inc[IDX_W-1:0];
		clk_sum  = {1'b0, clock_q} + (CLK_W+1)'(slen);
		orig_ext = CLK_W'(orig_rd);
		wt       = (clock_q >= orig_ext) ? (clock_q - orig_ext) : '0;
		tat_sum  = {1'b0, sum_tat_q} + (SUM_W+1)'(res_tat_q);
		wt_sum   = {1'b0, sum_wt_q} + (SUM_W+1)'(res_wt_q);
	end

	assign sts.req     = req_q;
	assign sts.no_work = (active_q == '0);
	assign sts.hit     = (rem_rd != '0);

	// table writes: append on load, shrink remaining time on run
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			rem_q[load_idx]  <= burst_q;
			orig_q[load_idx] <= burst_q;
		end else if (cmd.run) begin
			rem_q[scan_idx_q] <= rem_rd - slen;
		end
	end

	// quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	// scheduler state: count, live entries, cursor, clock, totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_cnt_q <= '0;
			active_q   <= '0;
			cursor_q   <= '0;
			clock_q    <= '0;
			sum_tat_q  <= '0;
			sum_wt_q   <= '0;
		end else if (cmd.clear) begin
			proc_cnt_q <= '0;
			active_q   <= '0;
			cursor_q   <= '0;
			clock_q    <= '0;
			sum_tat_q  <= '0;
			sum_wt_q   <= '0;
		end else begin
			if (cmd.load && !full) begin
				proc_cnt_q <= proc_cnt_q + CNT_W'(1);
				if (burst_q != '0) begin
					active_q <= active_q + CNT_W'(1);
				end
			end
			if (cmd.run) begin
				cursor_q <= idx_next;
				clock_q  <= clk_sum[CLK_W] ? CLOCK_MAX : clk_sum[CLK_W-1:0];
			end
			if (cmd.finish && res_fin_q) begin
				active_q <= active_q - CNT_W'(1);
			end
			if (cmd.accum && res_fin_q) begin
				sum_tat_q <= tat_sum[SUM_W] ? SUM_MAX : tat_sum[SUM_W-1:0];
				sum_wt_q  <= wt_sum[SUM_W] ? SUM_MAX : wt_sum[SUM_W-1:0];
			end
		end
	end

	// per-request registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= req_t'(req_type);
			burst_q    <= burst_time;
			scan_idx_q <= cursor_q;
			res_stat_q <= STAT_OK;
			res_pnum_q <= '0;
			res_slen_q <= '0;
			res_fin_q  <= 1'b0;
			res_tat_q  <= '0;
			res_wt_q   <= '0;
		end else begin
			if (cmd.load && full) begin
				res_stat_q <= STAT_FULL;
			end
			if (cmd.none) begin
				res_stat_q <= STAT_EMPTY;
			end
			if (cmd.scan_adv) begin
				scan_idx_q <= idx_next;
			end
			if (cmd.run) begin
				res_pnum_q <= PNUM_W'(scan_idx_q) + PNUM_W'(1);
				res_slen_q <= slen;
				res_fin_q  <= (rem_rd == slen);
			end
			if (cmd.finish && res_fin_q) begin
				res_tat_q <= clock_q;
				res_wt_q  <= wt;
			end
		end
	end

	// output register: snapshot of the result and the state after it
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_stat_q    <= res_stat_q;
			o_pnum_q    <= res_pnum_q;
			o_slen_q    <= res_slen_q;
			o_end_q     <= clock_q;
			o_fin_q     <= res_fin_q;
			o_tat_q     <= res_tat_q;
			o_wt_q      <= res_wt_q;
			o_done_q    <= (active_q == '0);
			o_sum_tat_q <= sum_tat_q;
			o_sum_wt_q  <= sum_wt_q;
		end
	end

	assign status           = o_stat_q;
	assign proc_number      = o_pnum_q;
	assign slice_length     = o_slen_q;
	assign slice_end        = o_end_q;
	assign finished         = o_fin_q;
	assign turnaround       = o_tat_q;
	assign waiting          = o_wt_q;
	assign all_done         = o_done_q;
	assign total_turnaround = o_sum_tat_q;
	assign total_waiting    = o_sum_wt_q;

endmodule

[rtl/round_robin_slice_scheduler.sv]
// Round-robin slice scheduler, top level: rrs_ctrl plus rrs_dp, uses rrs_pkg.
// Load, clear and unused requests go from accept through decode to emit.
// Step: decode, a scan of one entry per cycle past entries with no work left
// (0 to MAX_PROCS - 1 skipped), run, finish, accum, emit; with no work, decode to emit.
// Throughput: one request in flight; the next is taken once its result is registered.
// Reset (arst_n low): empty table, cursor, clock and totals zero, quantum 4.
module round_robin_slice_scheduler
	import rrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [TIME_W-1:0] burst_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [PNUM_W-1:0] proc_number,
	output logic [TIME_W-1:0] slice_length,
	output logic [CLK_W-1:0]  slice_end,
	output logic              finished,
	output logic [CLK_W-1:0]  turnaround,
	output logic [CLK_W-1:0]  waiting,
	output logic              all_done,
	output logic [SUM_W-1:0]  total_turnaround,
	output logic [SUM_W-1:0]  total_waiting
);

	cmd_t cmd;
	sts_t sts;

	rrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.req_type         (req_type),
		.burst_time       (burst_time),
		.status           (status),
		.proc_number      (proc_number),
		.slice_length     (slice_length),
		.slice_end        (slice_end),
		.finished         (finished),
		.turnaround       (turnaround),
		.waiting          (waiting),
		.all_done         (all_done),
		.total_turnaround (total_turnaround),
		.total_waiting    (total_waiting)
	);

`ifndef NO_ASSERTIONS
	// one request in flight: no second beat right after an accept
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a request is in flight");

	// an emitted result is visible on the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");

	// a failed request names no process and runs no time
	a_no_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK) |-> (proc_number == '0 && slice_length == '0))
		else $error("non-ok result carries a slice");

	// a completed process ends at the slice end and never waits past it
	a_finish_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> (turnaround == slice_end && waiting <= turnaround))
		else $error("finish times inconsistent");
`endif

endmodule
